@@ rtl/d4wf_pkg.sv @@
`timescale 1ns / 1ps
package d4wf_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int TAP_W       = 16;
	localparam int COEF_W      = 17;
	localparam int IDX_W       = 10;
	localparam int HALF_W      = 10;
	localparam int MIN_HALF    = 2;
	localparam int MAX_HALF    = 512;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int PROD_W      = 32;
	localparam int ACC_W       = 34;
	localparam int FRAC_W      = 15;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 32;
	localparam int OUT_PAD_W   = OUT_DATA_W - COEF_W - IDX_W;

	// q1.15 filter taps
	localparam logic signed [TAP_W-1:0] TAP0 = 16'sd15826;
	localparam logic signed [TAP_W-1:0] TAP1 = 16'sd27411;
	localparam logic signed [TAP_W-1:0] TAP2 = 16'sd7345;
	localparam logic signed [TAP_W-1:0] TAP3 = -16'sd4240;
	localparam logic signed [TAP_W-1:0] NTAP0 = -16'sd15826;
	localparam logic signed [TAP_W-1:0] NTAP2 = -16'sd7345;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_W - 1));

	typedef enum logic [3:0] {
		RES_APPROX      = 4'b0001,
		RES_DETAIL      = 4'b0010,
		RES_WRAP_APPROX = 4'b0100,
		RES_WRAP_DETAIL = 4'b1000
	} res_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp0;
		logic signed [SAMPLE_W-1:0] smp1;
		logic signed [SAMPLE_W-1:0] smp2;
		logic signed [SAMPLE_W-1:0] smp3;
		logic signed [SAMPLE_W-1:0] wrp0;
		logic signed [SAMPLE_W-1:0] wrp1;
		logic [IDX_W-1:0]           idx;
		logic                       last;
	} job_t;

endpackage

@@ rtl/d4wf_front.sv @@
`timescale 1ns / 1ps
module d4wf_front import d4wf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [HALF_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 q_full,
	output logic                 push,
	output job_t                 push_job,
	output logic [HALF_W-1:0]    half
);

	logic [HALF_W-1:0]          half_q;
	logic [HALF_W-1:0]          count_q;
	logic signed [SAMPLE_W-1:0] wrap_q [2];
	logic signed [SAMPLE_W-1:0] win_q [3];
	logic signed [SAMPLE_W-1:0] x;
	logic [HALF_W-1:0]          cfg_clamped;
	logic [HALF_W:0]            blen;
	logic                       accept;
	logic                       final_smp;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign x         = $signed(s_tdata[SAMPLE_W-1:0]);
	assign blen      = {half_q, 1'b0};
	assign final_smp = ({1'b0, count_q} + (HALF_W+1)'(1)) >= blen;
	assign half      = half_q;

	always_comb begin
		cfg_clamped = cfg_data;
		if (cfg_data < HALF_W'(MIN_HALF)) begin
			cfg_clamped = HALF_W'(MIN_HALF);
		end else if (cfg_data > HALF_W'(MAX_HALF)) begin
			cfg_clamped = HALF_W'(MAX_HALF);
		end
	end

	assign push = accept && count_q[0] && (count_q >= HALF_W'(3));

	always_comb begin
		push_job.smp0 = win_q[0];
		push_job.smp1 = win_q[1];
		push_job.smp2 = win_q[2];
		push_job.smp3 = x;
		push_job.wrp0 = wrap_q[0];
		push_job.wrp1 = wrap_q[1];
		push_job.idx  = IDX_W'((count_q - HALF_W'(3)) >> 1);
		push_job.last = final_smp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= HALF_W'(MIN_HALF);
			count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				half_q  <= cfg_clamped;
				count_q <= '0;
			end else if (accept) begin
				count_q <= final_smp ? '0 : count_q + HALF_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q[0] <= '0;
			wrap_q[1] <= '0;
			win_q[0]  <= '0;
			win_q[1]  <= '0;
			win_q[2]  <= '0;
		end else if (accept) begin
			if (count_q == HALF_W'(0)) begin
				wrap_q[0] <= x;
			end
			if (count_q == HALF_W'(1)) begin
				wrap_q[1] <= x;
			end
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= x;
		end
	end

endmodule

@@ rtl/d4wf_queue.sv @@
`timescale 1ns / 1ps
module d4wf_queue import d4wf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

@@ rtl/d4wf_back.sv @@
`timescale 1ns / 1ps
module d4wf_back import d4wf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  job_t                  head,
	input  logic                  empty,
	input  logic [HALF_W-1:0]     half,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	res_t                       r_q;
	res_t                       r_next;
	logic                       adv;
	logic                       issue;
	logic                       wrap_sel;
	logic                       det_sel;
	logic signed [SAMPLE_W-1:0] op [4];
	logic signed [TAP_W-1:0]    tap [4];
	logic [IDX_W-1:0]           base_idx;
	logic [IDX_W-1:0]           res_idx;

	logic signed [PROD_W-1:0]   prod_s1 [4];
	logic [IDX_W-1:0]           idx_s1;
	logic                       done_s1;
	logic                       vld_s1;

	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    rnd;
	logic [COEF_W-1:0]          coef_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       done_q;
	logic                       vld_q;

	assign adv   = !vld_q || m_tready;
	assign issue = !empty && adv;

	assign wrap_sel = (r_q == RES_WRAP_APPROX) || (r_q == RES_WRAP_DETAIL);
	assign det_sel  = (r_q == RES_DETAIL) || (r_q == RES_WRAP_DETAIL);

	assign pop = issue && (((r_q == RES_DETAIL) && !head.last) || (r_q == RES_WRAP_DETAIL));

	always_comb begin
		unique case (r_q)
			RES_APPROX:      r_next = RES_DETAIL;
			RES_DETAIL:      r_next = RES_WRAP_APPROX;
			RES_WRAP_APPROX: r_next = RES_WRAP_DETAIL;
			RES_WRAP_DETAIL: r_next = RES_APPROX;
			default:         r_next = RES_APPROX;
		endcase
		if (pop) begin
			r_next = RES_APPROX;
		end
	end

	always_comb begin
		if (wrap_sel) begin
			op[0] = head.smp2;
			op[1] = head.smp3;
			op[2] = head.wrp0;
			op[3] = head.wrp1;
		end else begin
			op[0] = head.smp0;
			op[1] = head.smp1;
			op[2] = head.smp2;
			op[3] = head.smp3;
		end
		if (det_sel) begin
			tap[0] = TAP3;
			tap[1] = NTAP2;
			tap[2] = TAP1;
			tap[3] = NTAP0;
		end else begin
			tap[0] = TAP0;
			tap[1] = TAP1;
			tap[2] = TAP2;
			tap[3] = TAP3;
		end
	end

	assign base_idx = wrap_sel ? IDX_W'(half - HALF_W'(1)) : head.idx;
	assign res_idx  = det_sel ? base_idx + IDX_W'(half) : base_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q    <= RES_APPROX;
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
			vld_q  <= vld_s1;
			if (issue) begin
				r_q <= r_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				prod_s1[k] <= op[k] * tap[k];
			end
			idx_s1  <= res_idx;
			done_s1 <= (r_q == RES_WRAP_DETAIL);
		end
	end

	assign acc = ACC_W'(prod_s1[0]) + ACC_W'(prod_s1[1])
		+ ACC_W'(prod_s1[2]) + ACC_W'(prod_s1[3]);
	assign rnd = acc + ROUND_BIAS;

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_q <= rnd[FRAC_W+COEF_W-1:FRAC_W];
			idx_q  <= idx_s1;
			done_q <= done_s1;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {OUT_PAD_W'(0), idx_q, coef_q};
	assign m_tlast  = done_q;

endmodule

@@ rtl/d4_wavelet_forward.sv @@
`timescale 1ns / 1ps
// forward d4 wavelet, one level, periodic wrap over blocks of 2*half_length samples
// s_* channel: one signed sample per request, s_tdata[15:0]
// m_* channel: one coefficient per request; tlast marks the last one of the block
// cfg_* channel: half_length write (clamped to 2..512), restarts the block count
// after every odd sample position from 3 on, an approximation and a detail follow;
// the last sample of a block adds the wrap pair, so four requests leave for it
// a sample's results pass through the job queue, the product register and the output register
// throughput: one sample per cycle; on average one coefficient per cycle leaves,
// set by the single issue slot of the back end (one coefficient per cycle)
// a four-entry job queue between front and back absorbs the extra wrap pair
// and receiver stalls; when it fills, s_tready drops
// a stall on m_tready freezes the back end pipeline and the output register
// reset: half_length is 2, block position, queue and pipeline are empty
module d4_wavelet_forward import d4wf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [HALF_W-1:0]     cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // coefficient, coefficient_index, zero pad
	output logic                  m_tlast
);

	logic              push;
	job_t              push_job;
	logic              pop;
	job_t              head;
	logic              q_empty;
	logic              q_full;
	logic [HALF_W-1:0] half;

	d4wf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job),
		.half     (half)
	);

	d4wf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	d4wf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (q_empty),
		.half    (half),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

`ifndef SYNTH
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job popped from empty queue");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
			(m_tdata[COEF_W+IDX_W-1:COEF_W] == IDX_W'({half, 1'b0} - 11'd1)))
		else $error("block end on wrong coefficient index");
`endif

endmodule
